### rtl/assert_macros.svh
// Assertion macros shared by the Sobel edge magnitude RTL.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Plain property, sampled on the rising edge, disabled while reset is low.
`define SEM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
// Same-cycle implication.
`define SEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");
`else
`define SEM_ASSERT(lbl, clk, rst_n, prop)
`define SEM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sem_pkg.sv
// Package for the Sobel edge magnitude block: payload structs, stage types, constants.
// No dependencies; used by the top level, sem_win_col and sem_sqrt_cell.
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int CFG_W      = 12;
    localparam int IN_ROW_W   = 13;
    localparam int GRAD_W     = 11;
    localparam int SQ_IN_W    = 16;
    localparam int SQ_REM_W   = 9;
    localparam int MAG_W      = 8;
    localparam int SQRT_STEPS = 8;

    localparam logic       OP_PIXEL = 1'b0;
    localparam logic       OP_DRAIN = 1'b1;

    localparam logic       CFG_FRAME_WIDTH  = 1'b0;
    localparam logic       CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [FW_W-1:0]  FW_RESET = 11'd640;
    localparam logic [FH_W-1:0]  FH_RESET = 12'd480;
    localparam logic [MAG_W-1:0] MAG_MAX  = 8'd255;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel;
    } t_pix_in;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } t_mag_out;

    // One column of the 3x3 window: top is two lines up, bot is the newest line.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_wcol;

    // State carried from one square-root cell to the next.
    typedef struct packed {
        logic                valid;
        logic                last;
        logic                sat;
        logic [SQ_IN_W-1:0]  s;
        logic [SQ_REM_W-1:0] rem;
        logic [MAG_W-1:0]    root;
    } t_sqrt_stage;

endpackage

### rtl/sobel_edge_magnitude.sv
// Top level of the Sobel 3x3 edge magnitude block.
// Depends on sem_pkg, sem_ram, sem_win_col, sem_sqrt_cell and assert_macros.svh.
//
// Usage: grey pixels enter in raster order on the i_pix channel (op selects a
// frame pixel or a drain step); gradient magnitudes leave on the o_mag channel.
// Both channels are valid/ready; a transfer happens when valid and ready are high.
// The window is centred, so the result for a pixel is produced by the transfer of
// the pixel one line plus one pixel later; drain steps after the frame push the
// last line out, and the frame's final result carries frame_end.
// Throughput is one transfer per clock while no result is stalled. A result passes
// through the line-store read, the window shift, the kernels, the squares and the
// chain of eight square-root cells, each of which settles one bit of the magnitude.
// The whole pipeline advances together; when the receiver stalls a held result,
// every stage holds and o_pix_ready drops until the result is taken.
// Reset (synchronous, active low) empties the pipeline, returns the frame
// counters to the first pixel and loads the default 640x480 frame size. The line
// stores are not cleared; entries outside the frame are masked to zero.
// The user writes frame sizes on the configuration port only while the block is idle; the block does not enforce it.
`include "assert_macros.svh"

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [sem_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_pix_valid,
    output logic                        o_pix_ready,
    input  sem_pkg::t_pix_in            i_pix,
    output logic                        o_mag_valid,
    input  logic                        i_mag_ready,
    output sem_pkg::t_mag_out           o_mag
);
    import sem_pkg::*;

    // Column counters index the line stores; the effective width needs one more bit
    // so that it can hold MAX_WIDTH itself.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = CW + 1;
    localparam int LW = (EW > FW_W) ? EW : FW_W;

    // ------------------------------------------------------------------
    // Configuration registers and effective frame size.
    // ------------------------------------------------------------------
    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= FW_RESET;
            r_fh <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_fw <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_fh <= i_cfg_data[FH_W-1:0];
                default:          r_fw <= r_fw;
            endcase
        end
    end

    logic [LW-1:0]       fw_l;
    logic [LW-1:0]       w_l;
    logic [EW-1:0]       w_eff;
    logic [FH_W-1:0]     h_eff;
    logic [IN_ROW_W-1:0] h_ext;

    // A width of zero acts as one, and a width past the line stores as their depth.
    always_comb begin
        fw_l  = LW'(r_fw);
        if (r_fw == '0) begin
            w_l = LW'(1);
        end else if (fw_l > LW'(MAX_WIDTH)) begin
            w_l = LW'(MAX_WIDTH);
        end else begin
            w_l = fw_l;
        end
        w_eff = EW'(w_l);
        h_eff = (r_fh == '0) ? FH_W'(1) : r_fh;
        h_ext = {1'b0, h_eff};
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage advances together.
    // ------------------------------------------------------------------
    logic adv;
    logic acc;
    logic step;
    t_sqrt_stage chain [SQRT_STEPS+1];

    assign adv         = !chain[SQRT_STEPS].valid || i_mag_ready;
    assign o_pix_ready = adv;
    assign acc         = i_pix_valid && adv;

    // ------------------------------------------------------------------
    // Input stage: position counters and output masks, known before any data.
    // ------------------------------------------------------------------
    logic [CW-1:0]       r_in_col;
    logic [IN_ROW_W-1:0] r_in_row;
    logic [CW-1:0]       r_out_col;
    logic [FH_W-1:0]     r_out_row;
    logic [CW-1:0]       n_in_col;
    logic [IN_ROW_W-1:0] n_in_row;
    logic [CW-1:0]       n_out_col;
    logic [FH_W-1:0]     n_out_row;

    logic                is_drain;
    logic                ignore;
    logic [PIX_W-1:0]    a_cur;
    logic                a_emit;
    logic                a_last;
    logic [EW-1:0]       col_p1;
    logic [EW-1:0]       ocol_p1;
    logic [IN_ROW_W-1:0] orow_p1;
    logic                col_wrap;
    logic                ocol_end;
    logic                orow_end;
    logic [2:0]          a_rv;
    logic [2:0]          a_cv;

    always_comb begin
        is_drain = (i_pix.op == OP_DRAIN);
        // A drain step before any pixel of the frame changes nothing.
        ignore   = is_drain && (r_in_row == '0) && (r_in_col == '0);
        step     = acc && !ignore;

        // Pixels past the frame's last line count as padding.
        a_cur  = (is_drain || (r_in_row >= h_ext)) ? '0 : i_pix.pixel;
        a_emit = (r_in_row >= IN_ROW_W'(2)) ||
                 ((r_in_row == IN_ROW_W'(1)) && (r_in_col != '0));

        col_p1   = EW'(r_in_col) + EW'(1);
        col_wrap = (col_p1 >= w_eff);
        ocol_p1  = EW'(r_out_col) + EW'(1);
        ocol_end = (ocol_p1 >= w_eff);
        orow_p1  = {1'b0, r_out_row} + IN_ROW_W'(1);
        orow_end = (orow_p1 >= h_ext);
        a_last   = orow_end && ocol_end;

        // Zero padding: neighbor rows and columns outside the frame are masked.
        a_rv = {!orow_end, 1'b1, (r_out_row != '0)};
        a_cv = {!ocol_end, 1'b1, (r_out_col != '0)};

        if (col_wrap) begin
            n_in_col = '0;
            n_in_row = (r_in_row == '1) ? r_in_row : r_in_row + IN_ROW_W'(1);
        end else begin
            n_in_col = CW'(col_p1);
            n_in_row = r_in_row;
        end
        n_out_col = r_out_col;
        n_out_row = r_out_row;

        if (a_emit) begin
            if (a_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (ocol_end) begin
                n_out_col = '0;
                n_out_row = r_out_row + FH_W'(1);
            end else begin
                n_out_col = CW'(ocol_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (step) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------
    // Line-store stage: the read issued at the transfer returns here, and the
    // column is written back as the item moves on.
    // ------------------------------------------------------------------
    logic             r_b_valid;
    logic             r_b_emit;
    logic             r_b_last;
    logic [CW-1:0]    r_b_col;
    logic [PIX_W-1:0] r_b_cur;
    logic [2:0]       r_b_rv;
    logic [2:0]       r_b_cv;
    logic             r_b_fwd;
    logic [PIX_W-1:0] r_b_fwd_up;
    logic [PIX_W-1:0] r_b_fwd_mid;
    logic             n_b_fwd;
    logic [PIX_W-1:0] q_up;
    logic [PIX_W-1:0] q_mid;
    logic [PIX_W-1:0] b_up;
    logic [PIX_W-1:0] b_mid;
    logic             st_we;

    // With a one-pixel line the next item reads the column being written in the
    // same cycle, so the written values are passed along directly.
    assign b_up    = r_b_fwd ? r_b_fwd_up  : q_up;
    assign b_mid   = r_b_fwd ? r_b_fwd_mid : q_mid;
    assign st_we   = adv && r_b_valid;
    assign n_b_fwd = st_we && (r_in_col == r_b_col);

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_upper (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_b_col),
        .i_wdata (b_mid),
        .i_re    (step),
        .i_raddr (r_in_col),
        .o_rdata (q_up)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_store_middle (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_b_col),
        .i_wdata (r_b_cur),
        .i_re    (step),
        .i_raddr (r_in_col),
        .o_rdata (q_mid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (adv) begin
            r_b_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_b_emit    <= a_emit;
            r_b_last    <= a_last;
            r_b_col     <= r_in_col;
            r_b_cur     <= a_cur;
            r_b_rv      <= a_rv;
            r_b_cv      <= a_cv;
            r_b_fwd     <= n_b_fwd;
            r_b_fwd_up  <= b_mid;
            r_b_fwd_mid <= r_b_cur;
        end
    end

    // ------------------------------------------------------------------
    // Window: three column cells, the newest column entering at cell 2.
    // ------------------------------------------------------------------
    t_wcol win [3];
    t_wcol win_in [3];

    assign win_in[2] = '{top: b_up, mid: b_mid, bot: r_b_cur};

    for (genvar k = 0; k < 3; k++) begin : g_win
        if (k < 2) begin : g_link
            assign win_in[k] = win[k+1];
        end
        sem_win_col u_col (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (st_we),
            .i_col   (win_in[k]),
            .o_col   (win[k])
        );
    end

    logic       r_c_valid;
    logic       r_c_last;
    logic [2:0] r_c_rv;
    logic [2:0] r_c_cv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (adv) begin
            r_c_valid <= r_b_valid && r_b_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_last <= r_b_last;
            r_c_rv   <= r_b_rv;
            r_c_cv   <= r_b_cv;
        end
    end

    // ------------------------------------------------------------------
    // Kernel stage: masked Sobel X and Y sums over the window.
    // ------------------------------------------------------------------
    function automatic logic signed [GRAD_W-1:0] masked(input logic [PIX_W-1:0] v,
                                                         input logic en);
        masked = en ? $signed({{(GRAD_W-PIX_W){1'b0}}, v}) : '0;
    endfunction

    logic signed [GRAD_W-1:0] p [3][3];
    logic signed [GRAD_W-1:0] c_gx;
    logic signed [GRAD_W-1:0] c_gy;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            p[0][c] = masked(win[c].top, r_c_rv[0] && r_c_cv[c]);
            p[1][c] = masked(win[c].mid, r_c_rv[1] && r_c_cv[c]);
            p[2][c] = masked(win[c].bot, r_c_rv[2] && r_c_cv[c]);
        end
        c_gx = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
        c_gy = (p[2][0] - p[0][0]) + ((p[2][1] - p[0][1]) <<< 1) + (p[2][2] - p[0][2]);
    end

    logic                     r_d_valid;
    logic                     r_d_last;
    logic signed [GRAD_W-1:0] r_d_gx;
    logic signed [GRAD_W-1:0] r_d_gy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (adv) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_last <= r_c_last;
            r_d_gx   <= c_gx;
            r_d_gy   <= c_gy;
        end
    end

    // ------------------------------------------------------------------
    // Square stage: gx^2 + gy^2, with anything from 65536 up saturating.
    // ------------------------------------------------------------------
    logic signed [2*GRAD_W-1:0] sq_x;
    logic signed [2*GRAD_W-1:0] sq_y;
    logic [2*GRAD_W-1:0]        sq_sum;
    t_sqrt_stage                r_e;

    assign sq_x   = r_d_gx * r_d_gx;
    assign sq_y   = r_d_gy * r_d_gy;
    assign sq_sum = $unsigned(sq_x) + $unsigned(sq_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e.valid <= 1'b0;
        end else if (adv) begin
            r_e.valid <= r_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_e.last <= r_d_last;
            r_e.sat  <= |sq_sum[2*GRAD_W-1:SQ_IN_W];
            r_e.s    <= sq_sum[SQ_IN_W-1:0];
            r_e.rem  <= '0;
            r_e.root <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain: one result bit per cell, most significant first.
    // ------------------------------------------------------------------
    assign chain[0] = r_e;

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
        sem_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_stage (chain[i]),
            .o_stage (chain[i+1])
        );
    end

    assign o_mag_valid     = chain[SQRT_STEPS].valid;
    assign o_mag.magnitude = chain[SQRT_STEPS].sat ? MAG_MAX : chain[SQRT_STEPS].root;
    assign o_mag.frame_end = chain[SQRT_STEPS].last;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    // Only a wrap from column zero back to column zero can make two
    // consecutive items share a line-store column.
    `SEM_ASSERT_IMP(a_fwd_col_zero, i_clk, i_rst_n, r_b_valid && r_b_fwd, r_b_col == '0)
    // The frame's last result returns every position counter to the frame start.
    `SEM_ASSERT(a_last_clears, i_clk, i_rst_n, (step && a_emit && a_last) |=> ((r_in_col == '0) && (r_in_row == '0) && (r_out_col == '0) && (r_out_row == '0)))
    // A stalled pipeline keeps the line-store stage and its column.
    `SEM_ASSERT(a_b_holds, i_clk, i_rst_n, (!adv && r_b_valid) |=> (r_b_valid && $stable(r_b_col)))
    // The root leaving the chain satisfies the remainder bound of the square root.
    `SEM_ASSERT_IMP(a_sqrt_rem, i_clk, i_rst_n, chain[SQRT_STEPS].valid && !chain[SQRT_STEPS].sat, chain[SQRT_STEPS].rem <= {chain[SQRT_STEPS].root, 1'b0})

endmodule

### rtl/sem_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies. A read at the address being written returns the old data.
module sem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sem_win_col.sv
// One column cell of the 3x3 Sobel window; loads its neighbor's column on a shift.
// Depends on sem_pkg for the column type.
module sem_win_col (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  sem_pkg::t_wcol i_col,
    output sem_pkg::t_wcol o_col
);
    import sem_pkg::*;

    t_wcol r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

### rtl/sem_sqrt_cell.sv
// One cell of the pipelined integer square root: settles one result bit per cell.
// Depends on sem_pkg for the stage type.
module sem_sqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  sem_pkg::t_sqrt_stage i_stage,
    output sem_pkg::t_sqrt_stage o_stage
);
    import sem_pkg::*;

    t_sqrt_stage             r_stage;
    t_sqrt_stage             n_stage;
    logic [SQ_REM_W+1:0]     rem_sh;
    logic [SQ_REM_W+1:0]     trial;
    logic                    take;

    // Restoring step: bring down two radicand bits, try root*4+1.
    always_comb begin
        rem_sh = {i_stage.rem, i_stage.s[SQ_IN_W-1 -: 2]};
        trial  = {1'b0, i_stage.root, 2'b01};
        take   = (rem_sh >= trial);

        n_stage       = i_stage;
        n_stage.s     = {i_stage.s[SQ_IN_W-3:0], 2'b00};
        n_stage.rem   = take ? SQ_REM_W'(rem_sh - trial) : SQ_REM_W'(rem_sh);
        n_stage.root  = {i_stage.root[MAG_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid <= n_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_stage.last <= n_stage.last;
            r_stage.sat  <= n_stage.sat;
            r_stage.s    <= n_stage.s;
            r_stage.rem  <= n_stage.rem;
            r_stage.root <= n_stage.root;
        end
    end

    assign o_stage = r_stage;

endmodule
